>>> hw/rtl/msm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msm_pkg;

    // Geometry. STORE_DEPTH must be a power of two: store addresses wrap
    // by dropping the high bits.
    localparam int NUM_SLOTS   = 8;
    localparam int STORE_DEPTH = 65536;

    localparam int SAMPLE_W   = 16;
    localparam int ADDR_W     = 16;
    localparam int LEN_W      = 17;
    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int STORE_AW   = $clog2(STORE_DEPTH);
    localparam int ADDR_SUM_W = ((STORE_AW > LEN_W) ? STORE_AW : LEN_W) + 1;
    localparam int ACC_W      = SAMPLE_W + $clog2(NUM_SLOTS) + 1;

    // Saturation limits of the mixed sum
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sd32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32'sd32768);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUEUE = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_BUSY     = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef enum logic {
        KIND_QUEUE = 1'b0,
        KIND_MIX   = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_ACC,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_op                        op;
        logic [ADDR_W-1:0]          load_address;
        logic signed [SAMPLE_W-1:0] load_sample;
        logic [ADDR_W-1:0]          clip_start;
        logic [LEN_W-1:0]           clip_length;
    } t_in_item;

    typedef struct packed {
        t_kind                      result_kind;
        logic signed [SAMPLE_W-1:0] mixed_sample;
        t_status                    queue_status;
    } t_out_item;

    // One playback slot as held in the slot table
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  count;
        logic [LEN_W-1:0]  position;
    } t_slot_entry;

    // Sample store access: one write and one read request
    typedef struct packed {
        logic                wr_en;
        logic [STORE_AW-1:0] wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        logic                rd_en;
        logic [STORE_AW-1:0] rd_addr;
    } t_store_req;

endpackage

`default_nettype wire

>>> hw/rtl/msm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface msm_in_if;
    import msm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/msm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface msm_out_if;
    import msm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/msm_sample_store.sv
`timescale 1ns / 1ps
`default_nettype none

module msm_sample_store (
    input  wire logic                         i_clk,
    input  wire msm_pkg::t_store_req          i_req,
    output logic [msm_pkg::SAMPLE_W-1:0]      o_rd_data
);
    import msm_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> hw/rtl/multi_slot_sample_mixer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// i_in      sink       valid/ready        op, load_address, load_sample, clip_start, clip_length
// o_out     source     valid/ready        result_kind, mixed_sample, queue_status
//
// Load writes the sample store and gives no result. Queue is accepted, then its status
// goes to the output register. Tick is accepted, then walks the slot table: an idle or
// ending slot is evaluated only, a playing slot is evaluated (store read) and then
// accumulated; the saturated sum is then emitted.
// Reset clears the slot busy flags and all control; the sample store is not cleared.
// A new item is taken while a result waits in the output register; the next
// result then waits until that register is drained.

module multi_slot_sample_mixer_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    msm_in_if.sink     i_in,
    msm_out_if.source  o_out
);
    import msm_pkg::*;

    t_state                 r_state, n_state;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic [NUM_SLOTS-1:0]   r_busy, n_busy;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    t_out_item              r_res, n_res;
    t_out_item              r_out;
    logic                   r_out_valid;

    // Slot table memory
    t_slot_entry            r_slot_mem [NUM_SLOTS];
    t_slot_entry            r_slot_rd;
    logic                   slot_wr_en;
    logic [SLOT_W-1:0]      slot_wr_idx;
    t_slot_entry            slot_wr_data;

    t_store_req             store_req;
    logic [SAMPLE_W-1:0]    store_rd_data;

    logic                   in_xfer;
    logic                   out_load;
    logic                   any_free;
    logic [SLOT_W-1:0]      free_idx;
    logic                   slot_live;
    logic                   slot_last;
    logic [ADDR_SUM_W-1:0]  play_addr;
    logic [ADDR_SUM_W-1:0]  load_addr;
    t_out_item              emit_item;

    function automatic logic signed [SAMPLE_W-1:0] sat16(logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_W-1:0] res;
        if (v > SAT_MAX) begin
            res = SAMPLE_W'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            res = SAMPLE_W'(SAT_MIN);
        end else begin
            res = SAMPLE_W'(v);
        end
        return res;
    endfunction

    msm_sample_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (store_rd_data)
    );

    // Handshake
    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_load   = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Lowest free slot
    always_comb begin
        free_idx = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (!r_busy[s]) begin
                free_idx = SLOT_W'(s);
            end
        end
    end
    assign any_free = ~&r_busy;

    // Slot under evaluation
    assign slot_live = r_busy[r_slot] && (r_slot_rd.position < r_slot_rd.count);
    assign slot_last = (r_slot == SLOT_W'(NUM_SLOTS - 1));
    assign play_addr = ADDR_SUM_W'(r_slot_rd.base) + ADDR_SUM_W'(r_slot_rd.position);
    assign load_addr = ADDR_SUM_W'(i_in.data.load_address);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in.data.op == OP_QUEUE) begin
                        n_state = S_EMIT;
                    end else if (i_in.data.op == OP_TICK) begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (slot_live) begin
                    n_state = S_ACC;
                end else if (slot_last) begin
                    n_state = S_EMIT;
                end
            end
            S_ACC: begin
                n_state = slot_last ? S_EMIT : S_EVAL;
            end
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory accesses
    always_comb begin
        n_slot       = r_slot;
        n_busy       = r_busy;
        n_acc        = r_acc;
        n_res        = r_res;
        slot_wr_en   = 1'b0;
        slot_wr_idx  = r_slot;
        slot_wr_data = r_slot_rd;
        store_req    = '0;

        unique case (r_state)
            S_IDLE: begin
                n_slot = '0;
                n_acc  = '0;
                if (in_xfer) begin
                    unique case (i_in.data.op)
                        OP_LOAD: begin
                            store_req.wr_en   = 1'b1;
                            store_req.wr_addr = load_addr[STORE_AW-1:0];
                            store_req.wr_data = i_in.data.load_sample;
                        end
                        OP_QUEUE: begin
                            n_res.result_kind  = KIND_QUEUE;
                            n_res.mixed_sample = '0;
                            if (i_in.data.clip_length == '0) begin
                                n_res.queue_status = ST_EMPTY;
                            end else if (!any_free) begin
                                n_res.queue_status = ST_BUSY;
                            end else begin
                                n_res.queue_status    = ST_ACCEPTED;
                                slot_wr_en            = 1'b1;
                                slot_wr_idx           = free_idx;
                                slot_wr_data.base     = i_in.data.clip_start;
                                slot_wr_data.count    = i_in.data.clip_length;
                                slot_wr_data.position = '0;
                                n_busy[free_idx]      = 1'b1;
                            end
                        end
                        OP_TICK: begin
                            n_res.result_kind  = KIND_MIX;
                            n_res.mixed_sample = '0;
                            n_res.queue_status = ST_ACCEPTED;
                        end
                        default: ; // unused op: dropped
                    endcase
                end
            end
            S_EVAL: begin
                if (slot_live) begin
                    // fetch sample, advance position
                    store_req.rd_en       = 1'b1;
                    store_req.rd_addr     = play_addr[STORE_AW-1:0];
                    slot_wr_en            = 1'b1;
                    slot_wr_data.position = r_slot_rd.position + 1'b1;
                end else begin
                    // clip ended or slot idle: release it if busy, move to the next slot
                    if (r_busy[r_slot]) begin
                        n_busy[r_slot] = 1'b0;
                    end
                    if (!slot_last) begin
                        n_slot = r_slot + 1'b1;
                    end
                end
            end
            S_ACC: begin
                n_acc = r_acc + ACC_W'($signed(store_rd_data));
                if (!slot_last) begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_EMIT: ;
            default: ;
        endcase
    end

    // Result handed to the output register
    always_comb begin
        emit_item = r_res;
        if (r_res.result_kind == KIND_MIX) begin
            emit_item.mixed_sample = sat16(r_acc);
        end
    end

    // Slot table: write port and registered read at the next slot index
    always_ff @(posedge i_clk) begin
        if (slot_wr_en) begin
            r_slot_mem[slot_wr_idx] <= slot_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot_rd <= r_slot_mem[n_slot];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_busy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_busy  <= n_busy;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_res <= n_res;
        if (out_load) begin
            r_out <= emit_item;
        end
    end

    // Checks
    a_queue_zero_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.result_kind == KIND_QUEUE)
        |-> (o_out.data.mixed_sample == '0))
        else $error("queue result carries a nonzero mixed sample");

    a_queue_takes_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.data.op == OP_QUEUE && i_in.data.clip_length != '0 && !(&r_busy))
        |=> ($countones(r_busy) == $past($countones(r_busy)) + 1))
        else $error("accepted clip did not claim exactly one slot");

    a_read_busy_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_req.rd_en |-> (r_state == S_EVAL && r_busy[r_slot]))
        else $error("sample store read for an idle slot");

    a_acc_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> $past(store_req.rd_en))
        else $error("accumulate without a preceding store read");

endmodule

`default_nettype wire
